// ----- sv/tdpt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_pkg: shared constants of the trial-division prime tester
// Default number width, port width of the candidate word and the fixed
// small values that the test treats specially.
// ----------------------------------------------------------------------------
package tdpt_pkg;

	// width of the candidate port
	localparam int CANDIDATE_WIDTH = 32;

	// default width of the number under test
	localparam int DEF_NUMBER_WIDTH = 32;

	// smallest primes, both answered without division
	localparam int SMALL_PRIME_TWO   = 2;
	localparam int SMALL_PRIME_THREE = 3;

	// first odd trial divisor and the step between divisors
	localparam int FIRST_DIVISOR = 3;
	localparam int DIVISOR_STEP  = 2;

endpackage

// ----- sv/tdpt_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpt_divider: bit-serial restoring divider
// Shifts the dividend out one bit per cycle into a partial remainder and
// shifts one quotient bit in per cycle.
// ----------------------------------------------------------------------------
module tdpt_divider #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);

	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;

	logic [W:0]    rem_sh;
	logic [W:0]    diff;
	logic          ge;

	// one restoring step: shift in next dividend bit, trial subtract
	always_comb begin
		rem_sh = {rem_q, quo_q[W-1]};
		diff   = rem_sh - {1'b0, dvs_q};
		ge     = ~diff[W];
	end

	// control: counter and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// datapath shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : rem_sh[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ----- sv/trial_division_prime_test_unit.sv -----
`timescale 1ns / 1ps
// Words 0, 1, 2, 3 and even words are answered without the divider;
// otherwise the word is divided by each odd trial divisor in turn.
// One word at a time; the bit-serial divider sets the pace, with about
// 32768 trial divisors for a 32-bit prime near the top of range.
// A new word is taken while the previous result still waits in the output.
// Reset: asynchronous, active low; clears control state only.
// ----------------------------------------------------------------------------
// trial_division_prime_test_unit: trial-division primality tester
// Divides an odd candidate by 3, 5, 7, ... while divisor <= quotient and
// reports composite at the first zero remainder.
// ----------------------------------------------------------------------------
module trial_division_prime_test_unit #(
	parameter int NUMBER_WIDTH = tdpt_pkg::DEF_NUMBER_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [tdpt_pkg::CANDIDATE_WIDTH-1:0] candidate,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 is_prime
);

	import tdpt_pkg::*;

	localparam int W = NUMBER_WIDTH;

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]   state_q;
	logic [W-1:0] n_q;
	logic [W-1:0] d_q;
	logic         res_q;
	logic         out_valid_q;
	logic         is_prime_q;

	logic [W-1:0] n_in;
	logic         accept;
	logic         small_prime;
	logic         trivially_not;
	logic         slot_free;
	logic [W-1:0] d_next;
	logic         div_start;
	logic [W-1:0] div_dividend;
	logic [W-1:0] div_divisor;
	logic         div_done;
	logic [W-1:0] div_quo;
	logic [W-1:0] div_rem;
	logic         bound_hit;
	logic         zero_rem;

	// input word classification
	always_comb begin
		n_in          = W'(candidate);
		accept        = in_valid && in_ready;
		small_prime   = (n_in == W'(SMALL_PRIME_TWO)) || (n_in == W'(SMALL_PRIME_THREE));
		trivially_not = (n_in < W'(SMALL_PRIME_TWO)) || !n_in[0];
		slot_free     = !out_valid_q || out_ready;
		d_next        = d_q + W'(DIVISOR_STEP);
		bound_hit     = div_quo < d_q;
		zero_rem      = (div_rem == '0);
	end

	// divider launch: first divisor on accept, next odd divisor on restart
	always_comb begin
		div_start    = 1'b0;
		div_dividend = n_in;
		div_divisor  = W'(FIRST_DIVISOR);
		if (state_q == ST_RUN) begin
			div_dividend = n_q;
			div_divisor  = d_next;
			div_start    = div_done && !bound_hit && !zero_rem;
		end else begin
			div_start    = accept && !small_prime && !trivially_not;
		end
	end

	tdpt_divider #(
		.W(W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (small_prime || trivially_not) ? ST_DONE : ST_RUN;
					end
				end
				ST_RUN: begin
					if (div_done && (bound_hit || zero_rem)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			n_q   <= n_in;
			d_q   <= W'(FIRST_DIVISOR);
			res_q <= small_prime;
		end else if (state_q == ST_RUN && div_done) begin
			if (bound_hit) begin
				res_q <= 1'b1;
			end else if (zero_rem) begin
				res_q <= 1'b0;
			end else begin
				d_q <= d_next;
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && slot_free) begin
			is_prime_q <= res_q;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign is_prime  = is_prime_q;

	// an accepted word always leaves idle
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted word did not start processing");

	// divider completes only while a test is running
	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_RUN)
		else $error("divider finished outside run state");

	// trial divisor stays odd and at least three while running
	a_divisor_odd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> d_q[0] && d_q >= W'(FIRST_DIVISOR))
		else $error("trial divisor not odd or below three");

	// a new result word only follows the done state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result word raised without a finished test");

endmodule
